>>> hw/rtl/qalu_pkg.sv
// qalu_pkg: shared constants, operation codes and the pipeline item type of
// the quaternion arithmetic unit
// no dependencies
package qalu_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    localparam int PROD_W = 2 * COMP_WIDTH;
    localparam int WIDE_W = 2 * COMP_WIDTH + 2;
    localparam int NORM_W = 2 * COMP_WIDTH + 2;
    localparam int ROOT_W = COMP_WIDTH + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int DIV_W  = COMP_WIDTH + FRAC_BITS + 2;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_MUL       = 3'd1,
        OP_CONJ      = 3'd2,
        OP_NEG       = 3'd3,
        OP_NORM_SQ   = 3'd4,
        OP_NORMALIZE = 3'd5
    } qalu_op_t;

    // hamilton product operand selection: [lane][term], lane 0 is the scalar
    localparam logic [3:0][3:0][1:0] X_IDX = {
        {2'd2, 2'd1, 2'd3, 2'd0},
        {2'd1, 2'd3, 2'd2, 2'd0},
        {2'd3, 2'd2, 2'd1, 2'd0},
        {2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [3:0][3:0][1:0] Y_IDX = {
        {2'd1, 2'd2, 2'd0, 2'd3},
        {2'd3, 2'd1, 2'd0, 2'd2},
        {2'd2, 2'd3, 2'd0, 2'd1},
        {2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic [3:0][3:0] NEG_MASK = {4'b1000, 4'b1000, 4'b1000, 4'b1110};

    typedef struct packed {
        logic [2:0]                   mode;
        logic [3:0][WIDE_W-1:0]       wide;
        logic [3:0][COMP_WIDTH-1:0]   mag;
        logic [3:0]                   neg;
        logic                         norm_zero;
    } qalu_item_t;

endpackage

>>> hw/rtl/qalu_req_if.sv
// qalu_req_if: request channel of the quaternion unit, valid/ready with payload
// depends on qalu_pkg
interface qalu_req_if import qalu_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   mode;
    logic signed [COMP_WIDTH-1:0] a_scalar;
    logic signed [COMP_WIDTH-1:0] a_vec_i;
    logic signed [COMP_WIDTH-1:0] a_vec_j;
    logic signed [COMP_WIDTH-1:0] a_vec_k;
    logic signed [COMP_WIDTH-1:0] b_scalar;
    logic signed [COMP_WIDTH-1:0] b_vec_i;
    logic signed [COMP_WIDTH-1:0] b_vec_j;
    logic signed [COMP_WIDTH-1:0] b_vec_k;

    modport source (
        output valid, mode, a_scalar, a_vec_i, a_vec_j, a_vec_k,
               b_scalar, b_vec_i, b_vec_j, b_vec_k,
        input  ready
    );
    modport sink (
        input  valid, mode, a_scalar, a_vec_i, a_vec_j, a_vec_k,
               b_scalar, b_vec_i, b_vec_j, b_vec_k,
        output ready
    );
endinterface

>>> hw/rtl/qalu_rsp_if.sv
// qalu_rsp_if: result channel of the quaternion unit, valid/ready with payload
// depends on qalu_pkg
interface qalu_rsp_if import qalu_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] r_scalar;
    logic signed [COMP_WIDTH-1:0] r_vec_i;
    logic signed [COMP_WIDTH-1:0] r_vec_j;
    logic signed [COMP_WIDTH-1:0] r_vec_k;
    logic                         saturated;
    logic                         zero_norm;

    modport source (
        output valid, r_scalar, r_vec_i, r_vec_j, r_vec_k, saturated, zero_norm,
        input  ready
    );
    modport sink (
        input  valid, r_scalar, r_vec_i, r_vec_j, r_vec_k, saturated, zero_norm,
        output ready
    );
endinterface

>>> hw/rtl/quaternion_alu.sv
// quaternion_alu: top level of the quaternion arithmetic unit
// depends on qalu_pkg, qalu_req_if, qalu_rsp_if, qalu_front, qalu_sqrt, qalu_div
//
//   port  dir  payload
//   req   in   mode, a_scalar..a_vec_k, b_scalar..b_vec_k
//   rsp   out  r_scalar..r_vec_k, saturated, zero_norm
//
// one request per cycle, unless the output register holds a result that is not taken
// each request passes the front, the 17-stage square root and the 13-stage divider
// all stages advance together whenever the output register is empty or taken
// rst_n clears only the stage valid bits; no state is kept between requests
module quaternion_alu import qalu_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    qalu_req_if.sink    req,
    qalu_rsp_if.source  rsp
);

    localparam logic signed [WIDE_W-1:0] COMP_MAX =
        {{(WIDE_W - COMP_WIDTH + 1){1'b0}}, {(COMP_WIDTH - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] COMP_MIN =
        {{(WIDE_W - COMP_WIDTH + 1){1'b1}}, {(COMP_WIDTH - 1){1'b0}}};

    logic                       adv;
    logic [3:0][COMP_WIDTH-1:0] a_in, b_in;

    logic                  front_valid, sqrt_valid, div_valid;
    qalu_item_t            front_item, sqrt_item, div_item;
    logic [NORM_W-1:0]     front_norm;
    logic [ROOT_W-1:0]     sqrt_root;
    logic [3:0][QUO_W-1:0] div_quo;

    logic signed [WIDE_W-1:0]   val_c [4];
    logic [3:0][COMP_WIDTH-1:0] r_next, r_reg;
    logic                       sat_next, sat_reg, zn_next, zn_reg;
    logic                       out_v_reg;

    assign adv       = !out_v_reg || rsp.ready;
    assign req.ready = adv;

    assign a_in = {req.a_vec_k, req.a_vec_j, req.a_vec_i, req.a_scalar};
    assign b_in = {req.b_vec_k, req.b_vec_j, req.b_vec_i, req.b_scalar};

    qalu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req.valid),
        .mode      (req.mode),
        .a         (a_in),
        .b         (b_in),
        .out_valid (front_valid),
        .item      (front_item),
        .norm      (front_norm)
    );

    qalu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .in_norm   (front_norm),
        .out_valid (sqrt_valid),
        .out_item  (sqrt_item),
        .out_root  (sqrt_root)
    );

    qalu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sqrt_valid),
        .in_item   (sqrt_item),
        .in_root   (sqrt_root),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_quo   (div_quo)
    );

    // final select and saturation
    always_comb
    begin
        sat_next = 1'b0;
        zn_next  = (div_item.mode == OP_NORMALIZE) && div_item.norm_zero;
        for (int l = 0; l < 4; l++)
        begin
            if (div_item.mode == OP_NORMALIZE)
            begin
                if (div_item.norm_zero)
                    val_c[l] = '0;
                else if (div_item.neg[l])
                    val_c[l] = -WIDE_W'(div_quo[l]);
                else
                    val_c[l] = WIDE_W'(div_quo[l]);
            end
            else
            begin
                val_c[l] = div_item.wide[l];
            end
            if (val_c[l] > COMP_MAX)
            begin
                r_next[l] = COMP_WIDTH'(COMP_MAX);
                sat_next  = 1'b1;
            end
            else if (val_c[l] < COMP_MIN)
            begin
                r_next[l] = COMP_WIDTH'(COMP_MIN);
                sat_next  = 1'b1;
            end
            else
            begin
                r_next[l] = COMP_WIDTH'(val_c[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg   <= r_next;
            sat_reg <= sat_next;
            zn_reg  <= zn_next;
        end
    end

    assign rsp.valid     = out_v_reg;
    assign rsp.r_scalar  = r_reg[0];
    assign rsp.r_vec_i   = r_reg[1];
    assign rsp.r_vec_j   = r_reg[2];
    assign rsp.r_vec_k   = r_reg[3];
    assign rsp.saturated = sat_reg;
    assign rsp.zero_norm = zn_reg;

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while result stalled");

    a_zero_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.zero_norm |-> r_reg == '0 && !rsp.saturated)
        else $error("zero norm result not cleared");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        adv && div_valid |=> rsp.valid)
        else $error("divider result lost");

endmodule

>>> hw/rtl/qalu_front.sv
// qalu_front: input register, product stage and rounded sum stage
// (add, conjugate, negate, hamilton product, squared norm)
// depends on qalu_pkg
module qalu_front import qalu_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [2:0]                 mode,
    input  logic [3:0][COMP_WIDTH-1:0] a,
    input  logic [3:0][COMP_WIDTH-1:0] b,
    output logic                       out_valid,
    output qalu_item_t                 item,
    output logic [NORM_W-1:0]          norm
);

    localparam logic signed [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);

    logic                       v1_reg, v2_reg, v3_reg;
    logic [2:0]                 mode1_reg, mode2_reg;
    logic [3:0][COMP_WIDTH-1:0] a1_reg, b1_reg;

    logic [3:0][3:0][PROD_W-1:0] prod_next, prod2_reg;
    logic [3:0][WIDE_W-1:0]      simple_next, simple2_reg;
    logic [3:0][COMP_WIDTH-1:0]  mag_next, mag2_reg;
    logic [3:0]                  neg_next, neg2_reg;
    logic                        self_sq;
    logic signed [WIDE_W-1:0]    a_ext [4];
    logic signed [WIDE_W-1:0]    b_ext [4];

    logic signed [WIDE_W-1:0]    sum_c [4];
    logic signed [WIDE_W-1:0]    rnd_c [4];
    logic signed [WIDE_W-1:0]    term_c;
    qalu_item_t                  item_next, item_reg;
    logic [NORM_W-1:0]           norm_next, norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg   <= mode;
            a1_reg      <= a;
            b1_reg      <= b;
            mode2_reg   <= mode1_reg;
            prod2_reg   <= prod_next;
            simple2_reg <= simple_next;
            mag2_reg    <= mag_next;
            neg2_reg    <= neg_next;
            item_reg    <= item_next;
            norm_reg    <= norm_next;
        end
    end

    // products; norm modes square a on lane 0
    always_comb
    begin
        self_sq = (mode1_reg == OP_NORM_SQ) || (mode1_reg == OP_NORMALIZE);
        for (int l = 0; l < 4; l++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                prod_next[l][n] = $signed(a1_reg[X_IDX[l][n]])
                    * $signed(self_sq ? a1_reg[n] : b1_reg[Y_IDX[l][n]]);
            end
        end
        for (int n = 0; n < 4; n++)
        begin
            a_ext[n]    = WIDE_W'($signed(a1_reg[n]));
            b_ext[n]    = WIDE_W'($signed(b1_reg[n]));
            neg_next[n] = a1_reg[n][COMP_WIDTH-1];
            mag_next[n] = neg_next[n] ? -a1_reg[n] : a1_reg[n];
            case (mode1_reg)
                OP_ADD:  simple_next[n] = a_ext[n] + b_ext[n];
                OP_CONJ: simple_next[n] = (n == 0) ? a_ext[n] : -a_ext[n];
                OP_NEG:  simple_next[n] = -a_ext[n];
                default: simple_next[n] = '0;
            endcase
        end
    end

    // exact sums, then round half up on the fraction
    always_comb
    begin
        term_c = '0;
        for (int l = 0; l < 4; l++)
        begin
            sum_c[l] = '0;
            for (int n = 0; n < 4; n++)
            begin
                term_c = WIDE_W'($signed(prod2_reg[l][n]));
                if (mode2_reg == OP_MUL && NEG_MASK[l][n])
                    sum_c[l] = sum_c[l] - term_c;
                else
                    sum_c[l] = sum_c[l] + term_c;
            end
            rnd_c[l] = (sum_c[l] + ROUND_HALF) >>> FRAC_BITS;
        end
        item_next.mode      = mode2_reg;
        item_next.mag       = mag2_reg;
        item_next.neg       = neg2_reg;
        item_next.norm_zero = (sum_c[0] == '0);
        for (int l = 0; l < 4; l++)
        begin
            case (mode2_reg)
                OP_MUL:     item_next.wide[l] = rnd_c[l];
                OP_NORM_SQ: item_next.wide[l] = (l == 0) ? rnd_c[0] : '0;
                default:    item_next.wide[l] = simple2_reg[l];
            endcase
        end
        norm_next = NORM_W'(sum_c[0]);
    end

    assign out_valid = v3_reg;
    assign item      = item_reg;
    assign norm      = norm_reg;

endmodule

>>> hw/rtl/qalu_sqrt.sv
// qalu_sqrt: pipelined integer square root, one result bit per stage,
// carries the item alongside
// depends on qalu_pkg
module qalu_sqrt import qalu_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  qalu_item_t        in_item,
    input  logic [NORM_W-1:0] in_norm,
    output logic              out_valid,
    output qalu_item_t        out_item,
    output logic [ROOT_W-1:0] out_root
);

    logic [ROOT_W-1:0] v_reg;
    qalu_item_t        item_reg [ROOT_W];
    logic [NORM_W-1:0] n_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    logic [NORM_W-1:0]  n_src    [ROOT_W];
    logic [REM_W-1:0]   rem_src  [ROOT_W];
    logic [ROOT_W-1:0]  root_src [ROOT_W];
    logic [REM_W+1:0]   trial    [ROOT_W];
    logic [REM_W+1:0]   tval     [ROOT_W];
    logic [ROOT_W-1:0]  ge;
    logic [NORM_W-1:0]  n_next    [ROOT_W];
    logic [REM_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0]  root_next [ROOT_W];

    always_comb
    begin
        n_src[0]    = in_norm;
        rem_src[0]  = '0;
        root_src[0] = '0;
        for (int k = 1; k < ROOT_W; k++)
        begin
            n_src[k]    = n_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++)
        begin
            // bring down the next two bits and try root*4+1
            trial[k]     = {rem_src[k], n_src[k][NORM_W-1 -: 2]};
            tval[k]      = {2'b00, root_src[k], 2'b01};
            ge[k]        = (trial[k] >= tval[k]);
            rem_next[k]  = ge[k] ? REM_W'(trial[k] - tval[k]) : REM_W'(trial[k]);
            root_next[k] = {root_src[k][ROOT_W-2:0], ge[k]};
            n_next[k]    = n_src[k] << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= in_item;
            for (int k = 1; k < ROOT_W; k++)
                item_reg[k] <= item_reg[k-1];
            for (int k = 0; k < ROOT_W; k++)
            begin
                n_reg[k]    <= n_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_item  = item_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

>>> hw/rtl/qalu_div.sv
// qalu_div: four-lane pipelined restoring divider, one quotient bit per stage,
// gives round_half_up(|a| * 2^FRAC_BITS / length) for each component
// depends on qalu_pkg
module qalu_div import qalu_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  qalu_item_t            in_item,
    input  logic [ROOT_W-1:0]     in_root,
    output logic                  out_valid,
    output qalu_item_t            out_item,
    output logic [3:0][QUO_W-1:0] out_quo
);

    logic [QUO_W-1:0]            v_reg;
    qalu_item_t                  item_reg [QUO_W];
    logic [ROOT_W:0]             dvs_reg  [QUO_W];
    logic [3:0][DIV_W-1:0]       rem_reg  [QUO_W];
    logic [3:0][QUO_W-1:0]       quo_reg  [QUO_W];

    logic [ROOT_W:0]             dvs_src  [QUO_W];
    logic [3:0][DIV_W-1:0]       rem_src  [QUO_W];
    logic [3:0][QUO_W-1:0]       quo_src  [QUO_W];
    logic [DIV_W-1:0]            shifted  [QUO_W];
    logic [3:0][DIV_W-1:0]       rem_next [QUO_W];
    logic [3:0][QUO_W-1:0]       quo_next [QUO_W];
    logic                        ge;

    always_comb
    begin
        // (m * 2^(F+1) + L) / (2L) rounds m * 2^F / L half up
        dvs_src[0] = {in_root, 1'b0};
        quo_src[0] = '0;
        for (int l = 0; l < 4; l++)
            rem_src[0][l] = (DIV_W'(in_item.mag[l]) << (FRAC_BITS + 1)) + DIV_W'(in_root);
        for (int k = 1; k < QUO_W; k++)
        begin
            dvs_src[k] = dvs_reg[k-1];
            rem_src[k] = rem_reg[k-1];
            quo_src[k] = quo_reg[k-1];
        end
        ge = 1'b0;
        for (int k = 0; k < QUO_W; k++)
        begin
            shifted[k] = DIV_W'(dvs_src[k]) << (QUO_W - 1 - k);
            for (int l = 0; l < 4; l++)
            begin
                ge = (rem_src[k][l] >= shifted[k]);
                rem_next[k][l] = ge ? rem_src[k][l] - shifted[k] : rem_src[k][l];
                quo_next[k][l] = {quo_src[k][l][QUO_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[QUO_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= in_item;
            for (int k = 1; k < QUO_W; k++)
                item_reg[k] <= item_reg[k-1];
            for (int k = 0; k < QUO_W; k++)
            begin
                dvs_reg[k] <= dvs_src[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_item  = item_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];

endmodule

>>> sim/tb.sv
// tb: self-checking bench for quaternion_alu, random bursts against a local predictor
// depends on qalu_pkg, qalu_req_if, qalu_rsp_if and the quaternion_alu rtl
module tb;
    import qalu_pkg::*;

    typedef struct {
        logic [2:0]        mode;
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
    } quat_req_t;

    typedef struct {
        logic signed [15:0] r [4];
        logic               sat;
        logic               zn;
    } quat_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    qalu_req_if req ();
    qalu_rsp_if rsp ();

    quaternion_alu u_dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always #5 clk = ~clk;

    quat_req_t pending_q [$];
    quat_res_t expected_q [$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    bit        drain_hold = 1'b0;
    int        hold_off = 0;
    longint    cycles = 0;

    // exact sum divided by 2^FRAC_BITS, rounded half up
    function automatic longint frac_round(longint s);
        return (s + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned lo = 0, hi = 64'd4294967296, mid;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function automatic quat_res_t quat_predict(quat_req_t q);
        quat_res_t    res;
        longint       a [4], b [4], r [4];
        longint       m, qv, len, hi, lo;
        longint unsigned nsum;
        hi = (64'sd1 <<< 15) - 1;
        lo = -hi - 1;
        res.sat = 1'b0;
        res.zn = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            a[n] = q.a[n];
            b[n] = q.b[n];
            r[n] = 0;
        end
        case (q.mode)
            OP_ADD:
                for (int n = 0; n < 4; n++)
                    r[n] = a[n] + b[n];
            OP_MUL:
            begin
                r[0] = frac_round(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                r[1] = frac_round(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                r[2] = frac_round(a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3]);
                r[3] = frac_round(a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1]);
            end
            OP_CONJ:
            begin
                r[0] = a[0];
                for (int n = 1; n < 4; n++)
                    r[n] = -a[n];
            end
            OP_NEG:
                for (int n = 0; n < 4; n++)
                    r[n] = -a[n];
            OP_NORM_SQ:
                r[0] = frac_round(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
            OP_NORMALIZE:
            begin
                nsum = 0;
                for (int n = 0; n < 4; n++)
                    nsum += longint'(a[n] * a[n]);
                if (nsum == 0)
                    res.zn = 1'b1;
                else
                begin
                    len = isqrt(nsum);
                    for (int n = 0; n < 4; n++)
                    begin
                        m = (a[n] < 0) ? -a[n] : a[n];
                        qv = ((m <<< (FRAC_BITS + 1)) + len) / (len <<< 1);
                        r[n] = (a[n] < 0) ? -qv : qv;
                    end
                end
            end
            default: ;
        endcase
        for (int n = 0; n < 4; n++)
        begin
            if (r[n] > hi)
            begin
                r[n] = hi;
                res.sat = 1'b1;
            end
            else if (r[n] < lo)
            begin
                r[n] = lo;
                res.sat = 1'b1;
            end
            res.r[n] = r[n][15:0];
        end
        return res;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8192)) - 4096);
            3: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic quat_req_t rand_req();
        quat_req_t q;
        q.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
        for (int n = 0; n < 4; n++)
        begin
            q.a[n] = rand_comp();
            q.b[n] = rand_comp();
        end
        if ($urandom_range(0, 19) == 0)
            for (int n = 0; n < 4; n++)
                q.a[n] = 16'sd0;
        return q;
    endfunction

    initial
    begin
        quat_req_t q;
        logic signed [15:0] edge_vals [4];
        edge_vals = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd4096};
        for (int m = 0; m < 8; m++)
            for (int v = 0; v < 3; v++)
            begin
                q.mode = 3'(m);
                for (int n = 0; n < 4; n++)
                begin
                    q.a[n] = edge_vals[(v + n) % 4];
                    q.b[n] = edge_vals[(v + n + 1) % 4];
                end
                if (v == 2 && m == OP_NORMALIZE)
                    for (int n = 0; n < 4; n++)
                        q.a[n] = 16'sd0;
                pending_q.push_back(q);
            end
        for (int i = 0; i < 1250; i++)
            pending_q.push_back(rand_req());
    end

    // sender: bursts and gaps, plus one pause until everything has drained
    int  burst_left = 0;
    int  gap_left = 0;
    int  sent = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= '0;
            req.a_scalar <= '0;
            req.a_vec_i <= '0;
            req.a_vec_j <= '0;
            req.a_vec_k <= '0;
            req.b_scalar <= '0;
            req.b_vec_i <= '0;
            req.b_vec_j <= '0;
            req.b_vec_k <= '0;
        end
        else
        begin
            automatic bit can_send;
            automatic quat_req_t q;
            if (req.valid && req.ready)
            begin
                expected_q.push_back(quat_predict(pending_q.pop_front()));
                sent = sent + 1;
                if (sent == 700)
                    drain_hold = 1'b1;
            end
            if (drain_hold && expected_q.size() == 0)
                drain_hold = 1'b0;
            can_send = pending_q.size() > 0 && !drain_hold;
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                can_send = 1'b0;
            end
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (can_send && !(req.valid && !req.ready))
                burst_left = burst_left - 1;
            if (req.valid && !req.ready)
                ;
            else if (can_send)
            begin
                q = pending_q[0];
                req.valid <= 1'b1;
                req.mode <= q.mode;
                req.a_scalar <= q.a[0];
                req.a_vec_i <= q.a[1];
                req.a_vec_j <= q.a[2];
                req.a_vec_k <= q.a[3];
                req.b_scalar <= q.b[0];
                req.b_vec_i <= q.b[1];
                req.b_vec_j <= q.b[2];
                req.b_vec_k <= q.b[3];
            end
            else
                req.valid <= 1'b0;
            if (pending_q.size() == 0 && !(req.valid && !req.ready))
                stim_done = 1'b1;
        end
    end

    // receiver: stall pattern, with one long hold-off early in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (cycles == 300)
                hold_off = 200;
            if (hold_off > 0)
            begin
                hold_off = hold_off - 1;
                rsp.ready <= 1'b0;
            end
            else if (cycles % 500 < 150)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            automatic quat_res_t e;
            automatic quat_res_t got;
            got.r = '{rsp.r_scalar, rsp.r_vec_i, rsp.r_vec_j, rsp.r_vec_k};
            got.sat = rsp.saturated;
            got.zn = rsp.zero_norm;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                errors = errors + 1;
            end
            else
            begin
                e = expected_q.pop_front();
                for (int n = 0; n < 4; n++)
                    if (got.r[n] !== e.r[n])
                    begin
                        $display("%0t: component %0d expected %0d got %0d",
                                 $time, n, e.r[n], got.r[n]);
                        errors = errors + 1;
                    end
                if (got.sat !== e.sat)
                begin
                    $display("%0t: saturated expected %b got %b", $time, e.sat, got.sat);
                    errors = errors + 1;
                end
                if (got.zn !== e.zn)
                begin
                    $display("%0t: zero_norm expected %b got %b", $time, e.zn, got.zn);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && expected_q.size() == 0);
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/qalu_pkg.sv
hw/rtl/qalu_req_if.sv
hw/rtl/qalu_rsp_if.sv
hw/rtl/qalu_front.sv
hw/rtl/qalu_sqrt.sv
hw/rtl/qalu_div.sv
hw/rtl/quaternion_alu.sv
sim/tb.sv
